// File: rtl/core/pchr_pkg.sv
// Shared constants and types of the point cloud height raster.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pchr_pkg;

  localparam int GRID  = 8;                   // pixels per row and per column
  localparam int NPIX  = GRID * GRID;
  localparam int AW    = $clog2(NPIX);        // store address width
  localparam int GW    = $clog2(GRID);        // row / column counter width
  localparam int RC_W  = 3;                   // row / column field width on the port
  localparam int QW    = $clog2(GRID + 1);    // axis quotient bits, quotient <= GRID
  localparam int VBITS = 8;                   // height quotient bits
  localparam int LAT   = VBITS + 1;           // stages after the input register
  localparam int ACC_ST = 4;                  // stages of the acceptance test
  localparam int VMAX  = 255;

  localparam logic [14:0]        RANGE_RST = 15'd2560;
  localparam logic signed [15:0] COS_RST   = -16'sd8192;

  typedef enum logic [0:0] {
    CFG_RANGE = 1'b0,
    CFG_COS   = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    KIND_POINT = 1'b0,
    KIND_EOF   = 1'b1
  } kind_t;

  // request leaving the arithmetic pipeline toward the store
  typedef struct packed {
    logic            vld;
    logic            eof;
    logic            keep;
    logic [GW-1:0]   row;
    logic [GW-1:0]   col;
    logic [VBITS-1:0] val;
  } pix_req_t;

endpackage

`default_nettype wire

// File: rtl/core/pchr_accept.sv
// Range and field-of-view test of a point, four stages plus alignment delay.
// Depends on pchr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pchr_accept (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [15:0]  x,
  input  wire logic signed [15:0]  y,
  input  wire logic signed [15:0]  z,
  input  wire logic [14:0]         range_lim,
  input  wire logic signed [15:0]  cos_lim,
  output logic                     keep
);
  import pchr_pkg::*;

  localparam int KD = LAT - ACC_ST;

  logic signed [31:0] xsq_s, ysq_s, zsq_s, csq_s;
  logic [30:0] xsq_r, ysq_r, zsq_r, ac2_1_r;
  logic [29:0] rr_r;
  logic        zneg1_r, cpos1_r;

  logic [31:0] d2_s;
  logic [31:0] d2_r;
  logic [30:0] zsq2_r, ac2_2_r;
  logic        drop2_r, zneg2_r, cpos2_r;

  logic [62:0] rhs_r;
  logic [58:0] lhs_r;
  logic        drop3_r, zneg3_r, cpos3_r;

  logic        fov_ok;
  logic        keep4_r;
  logic [KD-1:0] keep_dly_r;

  always_comb begin
    xsq_s = x * x;
    ysq_s = y * y;
    zsq_s = z * z;
    csq_s = cos_lim * cos_lim;
    d2_s  = 32'(xsq_r) + 32'(ysq_r) + 32'(zsq_r);
  end

  always_comb begin
    if (!cpos3_r && !zneg3_r) begin
      fov_ok = 1'b1;
    end else if (cpos3_r && zneg3_r) begin
      fov_ok = 1'b0;
    end else if (!cpos3_r) begin
      fov_ok = (63'(lhs_r) <= rhs_r);
    end else begin
      fov_ok = (63'(lhs_r) >= rhs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // squares
      xsq_r   <= xsq_s[30:0];
      ysq_r   <= ysq_s[30:0];
      zsq_r   <= zsq_s[30:0];
      ac2_1_r <= csq_s[30:0];
      rr_r    <= 30'(range_lim) * 30'(range_lim);
      zneg1_r <= z[15];
      cpos1_r <= !cos_lim[15] && (cos_lim != 16'sd0);
      // distance and range
      d2_r    <= d2_s;
      drop2_r <= (d2_s == 32'd0) || (d2_s > 32'(rr_r));
      zsq2_r  <= zsq_r;
      ac2_2_r <= ac2_1_r;
      zneg2_r <= zneg1_r;
      cpos2_r <= cpos1_r;
      // cone test operands: (z*16384)^2 against c^2 * d2
      rhs_r   <= 63'(ac2_2_r) * 63'(d2_r);
      lhs_r   <= {zsq2_r, 28'd0};
      drop3_r <= drop2_r;
      zneg3_r <= zneg2_r;
      cpos3_r <= cpos2_r;
      keep4_r <= !drop3_r && fov_ok;
      // align with the divider
      keep_dly_r <= {keep_dly_r[KD-2:0], keep4_r};
    end
  end

  assign keep = keep_dly_r[KD-1];

endmodule

`default_nettype wire

// File: rtl/core/pchr_quot.sv
// Pipelined restoring dividers: row and column from x and y, height from z.
// One quotient bit per stage; depends on pchr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pchr_quot (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [15:0]  x,
  input  wire logic signed [15:0]  y,
  input  wire logic signed [15:0]  z,
  input  wire logic [14:0]         range_lim,
  output logic [pchr_pkg::GW-1:0]  row,
  output logic [pchr_pkg::GW-1:0]  col,
  output logic [pchr_pkg::VBITS-1:0] val
);
  import pchr_pkg::*;

  localparam int NW  = 17 + $clog2(GRID);  // axis numerator width
  localparam int AXW = NW + QW;
  localparam int VW  = 24;                 // height numerator width

  logic signed [17:0] sx, sy;
  logic [NW-1:0] nx, ny;
  logic [VW-1:0] nz;

  logic [NW-1:0]    xrem_r [VBITS+1];
  logic [NW-1:0]    yrem_r [VBITS+1];
  logic [VW-1:0]    zrem_r [VBITS+1];
  logic [QW-1:0]    xq_r   [VBITS+1];
  logic [QW-1:0]    yq_r   [VBITS+1];
  logic [VBITS-1:0] zq_r   [VBITS+1];

  logic [NW-1:0]    xrem_nxt [VBITS+1];
  logic [NW-1:0]    yrem_nxt [VBITS+1];
  logic [VW-1:0]    zrem_nxt [VBITS+1];
  logic [QW-1:0]    xq_nxt   [VBITS+1];
  logic [QW-1:0]    yq_nxt   [VBITS+1];
  logic [VBITS-1:0] zq_nxt   [VBITS+1];

  // numerators: (coord + r) * GRID over 2r, z * 255 over r
  always_comb begin
    sx = 18'(x) + $signed({3'b000, range_lim});
    sy = 18'(y) + $signed({3'b000, range_lim});
    nx = (sx > 18'sd0) ? NW'(sx[16:0]) * NW'(GRID) : '0;
    ny = (sy > 18'sd0) ? NW'(sy[16:0]) * NW'(GRID) : '0;
    nz = (z > 16'sd0) ? VW'(z[14:0]) * VW'(VMAX) : '0;
  end

  always_comb begin
    for (int k = 0; k <= VBITS; k++) begin
      xrem_nxt[k] = '0;
      yrem_nxt[k] = '0;
      zrem_nxt[k] = '0;
      xq_nxt[k]   = '0;
      yq_nxt[k]   = '0;
      zq_nxt[k]   = '0;
    end
    for (int k = 1; k <= VBITS; k++) begin
      xrem_nxt[k] = xrem_r[k-1];
      yrem_nxt[k] = yrem_r[k-1];
      zrem_nxt[k] = zrem_r[k-1];
      xq_nxt[k]   = xq_r[k-1];
      yq_nxt[k]   = yq_r[k-1];
      zq_nxt[k]   = zq_r[k-1];
      if (k <= QW) begin
        if (AXW'(xrem_r[k-1]) >= (AXW'({range_lim, 1'b0}) << (QW - k))) begin
          xrem_nxt[k] = NW'(AXW'(xrem_r[k-1]) - (AXW'({range_lim, 1'b0}) << (QW - k)));
          xq_nxt[k][QW-k] = 1'b1;
        end
        if (AXW'(yrem_r[k-1]) >= (AXW'({range_lim, 1'b0}) << (QW - k))) begin
          yrem_nxt[k] = NW'(AXW'(yrem_r[k-1]) - (AXW'({range_lim, 1'b0}) << (QW - k)));
          yq_nxt[k][QW-k] = 1'b1;
        end
      end
      if (zrem_r[k-1] >= (VW'(range_lim) << (VBITS - k))) begin
        zrem_nxt[k] = zrem_r[k-1] - (VW'(range_lim) << (VBITS - k));
        zq_nxt[k][VBITS-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xrem_r[0] <= nx;
      yrem_r[0] <= ny;
      zrem_r[0] <= nz;
      xq_r[0]   <= '0;
      yq_r[0]   <= '0;
      zq_r[0]   <= '0;
      for (int k = 1; k <= VBITS; k++) begin
        xrem_r[k] <= xrem_nxt[k];
        yrem_r[k] <= yrem_nxt[k];
        zrem_r[k] <= zrem_nxt[k];
        xq_r[k]   <= xq_nxt[k];
        yq_r[k]   <= yq_nxt[k];
        zq_r[k]   <= zq_nxt[k];
      end
    end
  end

  // clamp the edge case coord == r onto the last row / column
  assign row = (xq_r[VBITS] > QW'(GRID - 1)) ? GW'(GRID - 1) : GW'(xq_r[VBITS]);
  assign col = (yq_r[VBITS] > QW'(GRID - 1)) ? GW'(GRID - 1) : GW'(yq_r[VBITS]);
  assign val = zq_r[VBITS];

endmodule

`default_nettype wire

// File: rtl/core/pchr_readout.sv
// Height store with per-pixel valid bits, frame readout sweep and output register.
// Depends on pchr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pchr_readout (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pchr_pkg::pix_req_t req,
  output logic                   pipe_en,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,
  output logic                   out_tlast
);
  import pchr_pkg::*;

  logic [VBITS-1:0] mem [NPIX];
  logic [NPIX-1:0]  vld_r;

  logic          busy_r;
  logic [GW-1:0] row_r, col_r;

  logic             s1_v_r, s1_last_r, s1_hit_r;
  logic [GW-1:0]    s1_row_r, s1_col_r;
  logic [VBITS-1:0] s1_q_r;

  logic             out_valid_r, out_last_r;
  logic [GW-1:0]    out_row_r, out_col_r;
  logic [VBITS-1:0] out_val_r;

  logic          commit, wr_en, rd_en, issue, last_pix;
  logic [AW-1:0] wr_addr, rd_addr;

  assign pipe_en  = !busy_r;
  assign commit   = pipe_en && req.vld;
  assign wr_en    = commit && (req.eof == KIND_POINT) && req.keep;
  assign wr_addr  = AW'(req.row) * AW'(GRID) + AW'(req.col);
  assign rd_en    = !out_valid_r || out_tready;
  assign issue    = busy_r && rd_en;
  assign rd_addr  = AW'(row_r) * AW'(GRID) + AW'(col_r);
  assign last_pix = (row_r == GW'(GRID - 1)) && (col_r == GW'(GRID - 1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req.val;
    end
    if (issue) begin
      s1_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      vld_r       <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit && (req.eof == KIND_EOF)) begin
        busy_r <= 1'b1;
        row_r  <= '0;
        col_r  <= '0;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        s1_v_r      <= issue;
        out_valid_r <= s1_v_r;
      end
      // sweep: read each pixel once and clear it behind the read
      if (issue) begin
        vld_r[rd_addr] <= 1'b0;
        if (col_r == GW'(GRID - 1)) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
        if (last_pix) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_row_r  <= row_r;
      s1_col_r  <= col_r;
      s1_last_r <= last_pix;
      s1_hit_r  <= vld_r[rd_addr];
    end
    if (rd_en && s1_v_r) begin
      out_row_r  <= s1_row_r;
      out_col_r  <= s1_col_r;
      out_last_r <= s1_last_r;
      out_val_r  <= s1_hit_r ? s1_q_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_val_r, RC_W'(out_col_r), RC_W'(out_row_r)};

`ifndef SYNTHESIS
  a_sweep_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(issue && last_pix))
    else $error("readout sweep ended before the last pixel");

  a_last_is_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |->
      (out_row_r == GW'(GRID - 1)) && (out_col_r == GW'(GRID - 1)))
    else $error("frame end flagged away from the last pixel");

  a_eof_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (req.eof == KIND_EOF)) |=> busy_r && (row_r == '0) && (col_r == '0))
    else $error("end of frame did not start the sweep at pixel zero");

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !$past(wr_en))
    else $error("store written during readout sweep");
`endif

endmodule

`default_nettype wire

// File: rtl/core/point_cloud_height_raster.sv
// Stages: a point reaches the store through the input register plus nine arithmetic
// stages, set by the 8-bit height divider, one quotient bit per stage.
// Throughput: one point per cycle outside a readout sweep. An end-of-frame request starts
// a sweep of all 64 pixels through the store read port, one pixel per cycle unless out_tready
// holds it off; input is held off during the sweep. Reset clears all pixel valid bits at once
// (grid reads as zero) and loads max_range = 2560 and cos_fov = -8192.
`timescale 1ns / 1ps
`default_nettype none

module point_cloud_height_raster (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // px [15:0], py [31:16], pz [47:32]
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // pixel_row [2:0], pixel_col [5:3], pixel_value [13:6]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import pchr_pkg::*;

  logic [14:0]        range_r;
  logic signed [15:0] cos_r;

  logic               s0_v_r, s0_eof_r;
  logic signed [15:0] s0_x_r, s0_y_r, s0_z_r;
  logic [LAT-1:0]     v_dly_r, eof_dly_r;

  logic             en, keep;
  logic [GW-1:0]    row, col;
  logic [VBITS-1:0] val;
  pix_req_t         req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= RANGE_RST;
      cos_r   <= COS_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RANGE: range_r <= cfg_data[14:0];
        CFG_COS:   cos_r   <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      v_dly_r <= '0;
    end else if (en) begin
      s0_v_r  <= in_tvalid;
      v_dly_r <= {v_dly_r[LAT-2:0], s0_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_eof_r  <= in_tuser;
      s0_x_r    <= in_tdata[15:0];
      s0_y_r    <= in_tdata[31:16];
      s0_z_r    <= in_tdata[47:32];
      eof_dly_r <= {eof_dly_r[LAT-2:0], s0_eof_r};
    end
  end

  pchr_accept u_accept (
    .clk       (clk),
    .en        (en),
    .x         (s0_x_r),
    .y         (s0_y_r),
    .z         (s0_z_r),
    .range_lim (range_r),
    .cos_lim   (cos_r),
    .keep      (keep)
  );

  pchr_quot u_quot (
    .clk       (clk),
    .en        (en),
    .x         (s0_x_r),
    .y         (s0_y_r),
    .z         (s0_z_r),
    .range_lim (range_r),
    .row       (row),
    .col       (col),
    .val       (val)
  );

  always_comb begin
    req.vld  = v_dly_r[LAT-1];
    req.eof  = eof_dly_r[LAT-1];
    req.keep = keep;
    req.row  = row;
    req.col  = col;
    req.val  = val;
  end

  pchr_readout u_readout (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .pipe_en    (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
